>>> rtl/fpba_pkg.sv
// Package for the fit-policy block allocator: item structs, sequencer states,
// policy and register codes, parameter defaults. No dependencies.
package fpba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_WIDTH_DEF = 16;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	// placement policies
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;
	localparam logic [1:0] POL_NEXT  = 2'd3;

	// item kinds
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	// register indexes (paddr[2])
	localparam logic REG_POLICY      = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

	typedef struct packed {
		logic        mode;
		logic [3:0]  block_index;
		logic [15:0] amount;
		logic        end_of_batch;
	} fpba_req_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  alloc_block;
		logic [15:0] remaining_after;
	} fpba_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} fpba_state_t;

endpackage

>>> rtl/fit_policy_block_allocator_top.sv
// Fit-policy block allocator top level: free-size table, scan sequencer, APB
// register port. Depends on fpba_pkg.

// A load item writes one block's free size; its result is valid in the next
// cycle. A request item scans the blocks in use one entry per cycle through
// the table's single read port and one shared fit comparator, then writes the
// reduced size back to the chosen block if one fits. Before the next item can
// be accepted, a request passes through its table reads, the last compare,
// the write-back, the result and the return to idle. Only one item is in
// flight; the input is ready again once its result has been taken. The user
// must set policy and block count through the APB port only while the block
// is idle; the block itself does not enforce this.
module fit_policy_block_allocator_top #(
	parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  fpba_pkg::fpba_req_t          req_item,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output fpba_pkg::fpba_rsp_t          rsp_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fpba_pkg::PADDR_W-1:0] paddr,
	input  logic [fpba_pkg::PDATA_W-1:0] pwdata,
	output logic [fpba_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import fpba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int NW = $clog2(MAX_BLOCKS + 1);

	fpba_state_t state_q, state_d;

	logic [1:0]            policy_q;
	logic [4:0]            bc_q;
	logic [IW-1:0]         rover_q;
	logic [SIZE_WIDTH-1:0] mem [MAX_BLOCKS];

	logic [SIZE_WIDTH-1:0] req_q;
	logic                  eob_q;
	logic [IW-1:0]         addr_q;
	logic [NW-1:0]         iss_q;
	logic                  rd_vld_q;
	logic [SIZE_WIDTH-1:0] rd_q;
	logic [IW-1:0]         rd_idx_q;
	logic                  found_q;
	logic [IW-1:0]         pick_q;
	logic [SIZE_WIDTH-1:0] pick_val_q;
	fpba_rsp_t             rsp_q;

	logic                  req_acc;
	logic                  rsp_acc;
	logic                  cfg_wr;
	logic                  scan_issue;
	logic                  scan_done;
	logic [NW-1:0]         n_c;
	logic [IW-1:0]         start_c;
	logic [IW-1:0]         addr_next_c;
	logic [SIZE_WIDTH-1:0] amount_c;
	logic                  load_ok_c;
	logic                  fits_c;
	logic                  take_c;
	logic [SIZE_WIDTH-1:0] remain_c;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [SIZE_WIDTH-1:0] mem_wdata;

	assign req_acc  = req_valid && req_ready;
	assign rsp_acc  = rsp_valid && rsp_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign rsp_item = rsp_q;
	assign pready   = 1'b1;

	// APB registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			bc_q     <= BLOCK_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_POLICY:      policy_q <= pwdata[1:0];
				REG_BLOCK_COUNT: bc_q     <= pwdata[4:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_POLICY:      prdata = {{(PDATA_W-2){1'b0}}, policy_q};
			REG_BLOCK_COUNT: prdata = {{(PDATA_W-5){1'b0}}, bc_q};
			default:         prdata = '0;
		endcase
	end

	// blocks in use, clamped to 1..MAX_BLOCKS
	always_comb begin
		if (bc_q == 5'd0)
			n_c = NW'(1);
		else if (32'(bc_q) > MAX_BLOCKS)
			n_c = NW'(MAX_BLOCKS);
		else
			n_c = NW'(bc_q);
	end

	always_comb begin
		if (policy_q == POL_NEXT && 32'(rover_q) < 32'(n_c))
			start_c = rover_q;
		else
			start_c = '0;
	end

	assign addr_next_c = (32'(addr_q) + 32'd1 == 32'(n_c)) ? '0 : addr_q + IW'(1);
	assign amount_c    = SIZE_WIDTH'(req_item.amount);
	assign load_ok_c   = 32'(req_item.block_index) < MAX_BLOCKS;

	// shared fit comparator and pick update
	assign fits_c = rd_q >= req_q;
	always_comb begin
		take_c = 1'b0;
		if (rd_vld_q && fits_c) begin
			priority if (!found_q)
				take_c = 1'b1;
			else if (policy_q == POL_BEST)
				take_c = rd_q < pick_val_q;
			else if (policy_q == POL_WORST)
				take_c = rd_q > pick_val_q;
			else
				take_c = 1'b0;
		end
	end

	assign remain_c = pick_val_q - req_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc)
					state_d = (req_item.mode == MODE_REQUEST) ? ST_SCAN : ST_OUT;
			end
			ST_SCAN: begin
				if (scan_done)
					state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_OUT;
			ST_OUT: begin
				if (rsp_acc)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = state_q == ST_IDLE;
		rsp_valid  = state_q == ST_OUT;
		scan_issue = state_q == ST_SCAN && iss_q < n_c;
		scan_done  = state_q == ST_SCAN && iss_q == n_c && rd_vld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rover_q  <= '0;
			iss_q    <= '0;
			rd_vld_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc) begin
				iss_q   <= '0;
				found_q <= 1'b0;
			end else if (scan_issue) begin
				iss_q <= iss_q + NW'(1);
			end
			if (take_c)
				found_q <= 1'b1;
			rd_vld_q <= scan_issue;
			if (state_q == ST_WRITE) begin
				if (eob_q)
					rover_q <= '0;
				else if (found_q && policy_q == POL_NEXT)
					rover_q <= pick_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q  <= amount_c;
			eob_q  <= req_item.end_of_batch;
			addr_q <= start_c;
		end else if (scan_issue) begin
			addr_q <= addr_next_c;
		end
		if (scan_issue) begin
			rd_q     <= mem[addr_q];
			rd_idx_q <= addr_q;
		end
		if (take_c) begin
			pick_q     <= rd_idx_q;
			pick_val_q <= rd_q;
		end
		if (req_acc && req_item.mode == MODE_LOAD) begin
			rsp_q.granted         <= 1'b0;
			rsp_q.alloc_block     <= req_item.block_index;
			rsp_q.remaining_after <= load_ok_c ? 16'(amount_c) : 16'd0;
		end else if (state_q == ST_WRITE) begin
			rsp_q.granted         <= found_q;
			rsp_q.alloc_block     <= found_q ? 4'(pick_q) : 4'd0;
			rsp_q.remaining_after <= found_q ? 16'(remain_c) : 16'd0;
		end
	end

	// free-size table: one write port, loads and grants share it
	always_comb begin
		if (state_q == ST_WRITE) begin
			mem_we    = found_q;
			mem_waddr = pick_q;
			mem_wdata = remain_c;
		end else begin
			mem_we    = req_acc && req_item.mode == MODE_LOAD && load_ok_c;
			mem_waddr = IW'(req_item.block_index);
			mem_wdata = amount_c;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("input taken again straight after an item");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && found_q) |-> pick_val_q >= req_q)
		else $error("granted block does not fit the request");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> iss_q <= n_c)
		else $error("scan ran past the blocks in use");
`endif

endmodule

>>> verif/fit_policy_block_allocator_top_tb.sv
// Self-checking testbench for fit_policy_block_allocator_top: a directed table, then random
// phases under randomly chosen placement policies. Needs fpba_pkg and the allocator RTL only.
module fit_policy_block_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpba_pkg::*;

	localparam int NB          = MAX_BLOCKS_DEF;
	localparam int RAND_ITEMS  = 420;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic      preset;
		fpba_rsp_t want;
	} rsp_note_t;

	typedef struct {
		fpba_req_t  item;
		logic [1:0] pol;
		logic [4:0] cnt;
		logic       preset;
		fpba_rsp_t  want;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	fpba_req_t            req_item  = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	fpba_rsp_t            rsp_item;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// allocator shadow state
	logic [15:0] free_tab [NB];
	logic [3:0]  rover_pos = '0;
	logic [1:0]  cur_policy = POL_FIRST;
	logic [4:0]  cur_count  = BLOCK_COUNT_RST;

	fpba_rsp_t  expected_q [$];
	rsp_note_t  note_q [$];
	dir_row_t   dir_rows [$];

	int  n_sent    = 0;
	int  n_done    = 0;
	int  n_grants  = 0;
	int  n_err     = 0;
	int  n_phases  = 0;
	int  cycles    = 0;
	int  stall_left = 0;
	bit  quiet     = 1'b0;

	fit_policy_block_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 12);
		return $urandom_range(20, 64);
	endfunction

	// placement as the allocator should do it; updates the shadow table and rover
	function automatic fpba_rsp_t place_item(fpba_req_t it);
		fpba_rsp_t r;
		int        n;
		int        pos;
		int        pick;
		r    = '0;
		pick = -1;
		n    = (cur_count == 0) ? 1 : (cur_count > NB) ? NB : int'(cur_count);
		if (it.mode == MODE_LOAD) begin
			free_tab[it.block_index] = it.amount;
			r.alloc_block     = it.block_index;
			r.remaining_after = it.amount;
			return r;
		end
		if (cur_policy == POL_NEXT) begin
			pos = (rover_pos < n) ? int'(rover_pos) : 0;
			for (int i = 0; i < n; i++) begin
				if (pick < 0 && free_tab[pos] >= it.amount)
					pick = pos;
				pos = (pos + 1 == n) ? 0 : pos + 1;
			end
		end else begin
			for (int i = 0; i < n; i++) begin
				if (free_tab[i] >= it.amount && (pick < 0 ||
						(cur_policy == POL_BEST && free_tab[i] < free_tab[pick]) ||
						(cur_policy == POL_WORST && free_tab[i] > free_tab[pick])))
					pick = i;
			end
		end
		if (pick >= 0) begin
			free_tab[pick] = free_tab[pick] - it.amount;
			if (cur_policy == POL_NEXT)
				rover_pos = 4'(pick);
			r.granted         = 1'b1;
			r.alloc_block     = 4'(pick);
			r.remaining_after = free_tab[pick];
		end
		if (it.end_of_batch)
			rover_pos = '0;
		return r;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 20)
				stall_left <= idle_len();
		end
	end

	always @(posedge clk) begin : mon
		fpba_rsp_t exp_rsp;
		fpba_rsp_t pred;
		rsp_note_t note;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				pred = place_item(req_item);
				note = '0;
				if (note_q.size() != 0)
					note = note_q.pop_front();
				expected_q.push_back(note.preset ? note.want : pred);
			end
			if (rsp_valid && rsp_ready) begin
				n_done++;
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, rsp_item);
					n_err++;
				end else begin
					exp_rsp = expected_q.pop_front();
					if (exp_rsp.granted)
						n_grants++;
					if (rsp_item.granted !== exp_rsp.granted) begin
						$display("%0t: granted expected %0d got %0d", $time,
							exp_rsp.granted, rsp_item.granted);
						n_err++;
					end
					if (rsp_item.alloc_block !== exp_rsp.alloc_block) begin
						$display("%0t: alloc_block expected %0d got %0d", $time,
							exp_rsp.alloc_block, rsp_item.alloc_block);
						n_err++;
					end
					if (rsp_item.remaining_after !== exp_rsp.remaining_after) begin
						$display("%0t: remaining_after expected %0d got %0d", $time,
							exp_rsp.remaining_after, rsp_item.remaining_after);
						n_err++;
					end
				end
			end
		end
	end

	function automatic logic [PADDR_W-1:0] reg_addr(logic idx);
		return {idx, 2'b00};
	endfunction

	task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] exp_val,
			logic [PDATA_W-1:0] mask);
		logic [PDATA_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((got & mask) !== (exp_val & mask)) begin
			$display("%0t: register at 0x%0h expected 0x%0h got 0x%0h", $time, a,
				exp_val & mask, got & mask);
			n_err++;
		end
		@(posedge clk);
	endtask

	// stop feeding items and let every outstanding result come back
	task automatic wait_allocator_idle();
		req_valid <= 1'b0;
		while (n_done != n_sent)
			@(posedge clk);
	endtask

	task automatic set_policy(logic [1:0] pol, logic [4:0] cnt);
		apb_write(reg_addr(REG_POLICY), PDATA_W'(pol));
		apb_write(reg_addr(REG_BLOCK_COUNT), PDATA_W'(cnt));
		cur_policy = pol;
		cur_count  = cnt;
		apb_check(reg_addr(REG_POLICY), PDATA_W'(pol), PDATA_W'(2'b11));
		apb_check(reg_addr(REG_BLOCK_COUNT), PDATA_W'(cnt), PDATA_W'(5'h1f));
		n_phases++;
	endtask

	task automatic send_item(fpba_req_t it, logic preset, fpba_rsp_t want);
		int        gap;
		rsp_note_t note;
		gap = quiet ? 0 : (($urandom_range(0, 99) < 40) ? idle_len() : 0);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note.preset = preset;
		note.want   = want;
		note_q.push_back(note);
		req_valid <= 1'b1;
		req_item  <= it;
		do
			@(posedge clk);
		while (!req_ready);
		n_sent++;
	endtask

	function automatic fpba_req_t random_item();
		fpba_req_t it;
		int        r;
		it.mode         = ($urandom_range(0, 99) < 30) ? MODE_LOAD : MODE_REQUEST;
		it.block_index  = 4'($urandom_range(0, 15));
		it.end_of_batch = ($urandom_range(0, 99) < 15);
		r = $urandom_range(0, 99);
		if (it.mode == MODE_LOAD)
			it.amount = (r < 8) ? 16'hffff : (r < 14) ? 16'h0 :
				(r < 30) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2000));
		else
			it.amount = (r < 5) ? 16'h0 : (r < 10) ? 16'($urandom_range(0, 65535)) :
				(r < 13) ? 16'hffff : 16'($urandom_range(1, 800));
		return it;
	endfunction

	function automatic void add_load(logic [3:0] idx, logic [15:0] amt, logic eob);
		dir_row_t row;
		row.item   = '{mode: MODE_LOAD, block_index: idx, amount: amt, end_of_batch: eob};
		row.pol    = POL_FIRST;
		row.cnt    = BLOCK_COUNT_RST;
		row.preset = 1'b1;
		row.want   = '{granted: 1'b0, alloc_block: idx, remaining_after: amt};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_req(logic [1:0] pol, logic [4:0] cnt, logic [15:0] amt,
			logic eob, logic refused);
		dir_row_t row;
		row.item   = '{mode: MODE_REQUEST, block_index: 4'hf, amount: amt, end_of_batch: eob};
		row.pol    = pol;
		row.cnt    = cnt;
		row.preset = refused;
		row.want   = '0;
		dir_rows.push_back(row);
	endfunction

	initial begin : stim
		int        rand_sent;
		int        len;
		int        r;
		logic [1:0] pol;
		logic [4:0] cnt;
		rand_sent = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check(reg_addr(REG_POLICY), PDATA_W'(POL_FIRST), PDATA_W'(2'b11));
		apb_check(reg_addr(REG_BLOCK_COUNT), PDATA_W'(BLOCK_COUNT_RST), PDATA_W'(5'h1f));

		// every block is loaded before the first request reads the table
		add_load(4'd0, 16'd100, 1'b0);
		add_load(4'd1, 16'd0, 1'b0);
		add_load(4'd2, 16'hffff, 1'b1);
		add_load(4'd3, 16'd300, 1'b0);
		add_load(4'd4, 16'd50, 1'b0);
		add_load(4'd5, 16'd80, 1'b0);
		add_load(4'd6, 16'd300, 1'b0);
		add_load(4'd7, 16'd1000, 1'b0);
		add_load(4'd8, 16'd60, 1'b0);
		add_load(4'd9, 16'd500, 1'b0);
		add_load(4'd10, 16'd70, 1'b0);
		add_load(4'd11, 16'd40, 1'b0);
		add_load(4'd12, 16'd90, 1'b0);
		add_load(4'd13, 16'd20, 1'b0);
		add_load(4'd14, 16'd10, 1'b0);
		add_load(4'd15, 16'd5, 1'b0);
		add_req(POL_FIRST, BLOCK_COUNT_RST, 16'd0, 1'b0, 1'b0);
		add_req(POL_FIRST, BLOCK_COUNT_RST, 16'hffff, 1'b0, 1'b0);
		add_req(POL_FIRST, BLOCK_COUNT_RST, 16'hffff, 1'b0, 1'b1);
		add_req(POL_BEST, BLOCK_COUNT_RST, 16'd60, 1'b0, 1'b0);
		add_req(POL_BEST, BLOCK_COUNT_RST, 16'd300, 1'b0, 1'b0);   // tie, lower index
		add_req(POL_WORST, BLOCK_COUNT_RST, 16'd500, 1'b0, 1'b0);
		add_req(POL_WORST, BLOCK_COUNT_RST, 16'd0, 1'b0, 1'b0);    // tie, lower index
		add_req(POL_NEXT, BLOCK_COUNT_RST, 16'd450, 1'b0, 1'b0);
		add_req(POL_NEXT, BLOCK_COUNT_RST, 16'd400, 1'b0, 1'b0);
		add_req(POL_NEXT, BLOCK_COUNT_RST, 16'd200, 1'b0, 1'b0);   // wraps past block 15
		add_req(POL_NEXT, BLOCK_COUNT_RST, 16'd1000, 1'b0, 1'b1);  // refused, rover kept
		add_req(POL_NEXT, 5'd4, 16'd10, 1'b1, 1'b0);               // rover beyond count
		add_req(POL_NEXT, 5'd0, 16'd90, 1'b0, 1'b0);               // count 0 acts as 1
		add_req(POL_FIRST, 5'd31, 16'd95, 1'b0, 1'b0);             // clamps to 16

		foreach (dir_rows[k]) begin
			if (dir_rows[k].pol != cur_policy || dir_rows[k].cnt != cur_count) begin
				wait_allocator_idle();
				set_policy(dir_rows[k].pol, dir_rows[k].cnt);
			end
			send_item(dir_rows[k].item, dir_rows[k].preset, dir_rows[k].want);
		end

		while (rand_sent < RAND_ITEMS) begin
			pol = 2'($urandom_range(0, 3));
			r   = $urandom_range(0, 9);
			cnt = (r == 0) ? 5'd0 : (r == 1) ? 5'd1 : (r == 2) ? 5'd16 : (r == 3) ? 5'd31 :
				(r == 4) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1, 16));
			wait_allocator_idle();
			quiet = ($urandom_range(0, 4) == 0);
			set_policy(pol, cnt);
			len = $urandom_range(15, 40);
			repeat (len) begin
				send_item(random_item(), 1'b0, '0);
				rand_sent++;
			end
		end

		wait_allocator_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_q.size());
			n_err++;
		end
		$display("Sent %0d items (%0d directed), %0d results checked, %0d grants,",
			n_sent, dir_rows.size(), n_done, n_grants);
		$display("over %0d policy/block-count settings; %0d mismatches.", n_phases, n_err);
		if (n_err == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> fit_policy_block_allocator_top.f
rtl/fpba_pkg.sv
rtl/fit_policy_block_allocator_top.sv
verif/fit_policy_block_allocator_top_tb.sv
